// ===== rtl/hash_join_linear_probe_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hash join probe block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HASH_JOIN_LINEAR_PROBE_MACROS_SVH
`define HASH_JOIN_LINEAR_PROBE_MACROS_SVH

// same-cycle implication
`define HJLP_ASSERT_NOW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("hjlp: same-cycle check failed");

// next-cycle implication
`define HJLP_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hjlp: next-cycle check failed");

`endif

// ===== rtl/hjlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hjlp_pkg
// Types and constants shared by the hash join probe controller and datapath.
// ----------------------------------------------------------------------------
package hjlp_pkg;

  localparam int KEY_W         = 32;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int TOT_W         = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int SHIFT_W       = 5;
  localparam int SBITS_W       = 4;
  localparam int MAX_SLOT_BITS = 10;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  localparam logic [KEY_W-1:0]   RST_HASH_FACTOR = 32'd2654435761;
  localparam logic [SHIFT_W-1:0] RST_HASH_SHIFT  = 5'd22;
  localparam logic [SBITS_W-1:0] RST_SLOT_BITS   = 4'd10;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PROBE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_FACTOR = 2'd0,
    REG_HASH_SHIFT  = 2'd1,
    REG_SLOT_BITS   = 2'd2,
    REG_EARLY_STOP  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ISSUE,
    ST_WALK,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;
    logic write_key;
    logic load_probe;
    logic hash;
    logic issue;
    logic walk;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic walk_stop;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/hjlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hjlp_ctrl
// Sequencer for table clear, key writes and the probe walk.
// ----------------------------------------------------------------------------
module hjlp_ctrl
  import hjlp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_opcode,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid && (opcode_t'(in_opcode) == OP_PROBE)) state_nxt = ST_HASH;
      ST_HASH:  state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_WALK;
      ST_WALK:  if (stat.walk_stop) state_nxt = ST_FIN;
      ST_FIN:   if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.write_key  = in_valid && (opcode_t'(in_opcode) == OP_WRITE);
        cmd.load_probe = in_valid && (opcode_t'(in_opcode) == OP_PROBE);
      end
      ST_HASH:  cmd.hash   = 1'b1;
      ST_ISSUE: cmd.issue  = 1'b1;
      ST_WALK:  cmd.walk   = 1'b1;
      ST_FIN:   cmd.finish = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/hjlp_datapath.sv =====
// ----------------------------------------------------------------------------
// hjlp_datapath
// Key table, config registers, hash unit, walk counters and result register.
// ----------------------------------------------------------------------------
module hjlp_datapath
  import hjlp_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IDX_W-1:0]      in_slot_index,
  input  logic [KEY_W-1:0]      in_key,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CNT_W-1:0]      out_match_count,
  output logic [TOT_W-1:0]      out_total_matches,
  output logic                  out_full_lap
);

  localparam int AW       = $clog2(SLOTS);
  localparam int SLOT_LOG = $clog2(SLOTS + 1) - 1;
  localparam int PB       = (SLOT_LOG < MAX_SLOT_BITS) ? SLOT_LOG : MAX_SLOT_BITS;

  // config
  logic [KEY_W-1:0]   hash_factor_r;
  logic [SHIFT_W-1:0] hash_shift_r;
  logic [SBITS_W-1:0] slot_bits_r;
  logic               early_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_factor_r <= RST_HASH_FACTOR;
      hash_shift_r  <= RST_HASH_SHIFT;
      slot_bits_r   <= RST_SLOT_BITS;
      early_stop_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HASH_FACTOR: hash_factor_r <= cfg_wdata;
        REG_HASH_SHIFT:  hash_shift_r  <= cfg_wdata[SHIFT_W-1:0];
        REG_SLOT_BITS:   slot_bits_r   <= cfg_wdata[SBITS_W-1:0];
        REG_EARLY_STOP:  early_stop_r  <= cfg_wdata[0];
        default:         early_stop_r  <= early_stop_r;
      endcase
    end
  end

  // active slot range: slot_bits clamped to [1, PB]
  logic [SBITS_W-1:0] act_bits;
  logic [PB:0]        act_cnt;

  always_comb begin
    if (slot_bits_r == '0) begin
      act_bits = SBITS_W'(1);
    end else if (slot_bits_r > SBITS_W'(PB)) begin
      act_bits = SBITS_W'(PB);
    end else begin
      act_bits = slot_bits_r;
    end
    act_cnt = (PB+1)'(1) << act_bits;
  end

  // clear sweep
  logic [AW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_r <= AW'(clr_r + 1'b1);
    end
  end

  // key table
  logic [KEY_W-1:0] mem [SLOTS];
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rdata_r;
  logic [PB-1:0]    pos_r, pos_nxt, home;

  always_comb begin
    if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = EMPTY_KEY;
    end else begin
      wr_en   = cmd.write_key && (32'(in_slot_index) < SLOTS);
      wr_addr = AW'(in_slot_index);
      wr_data = in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  // probe datapath
  logic [KEY_W-1:0]   key_r;
  logic [KEY_W-1:0]   prod_r;
  logic [KEY_W-1:0]   prod_lo;
  logic [PB-1:0]      mask_r;
  logic [PB:0]        active_r;
  logic [PB:0]        visited_r, vis_inc;
  logic [PB:0]        count_r;
  logic               lap_r;
  logic               is_empty, is_match, hit_lap;

  // low half of the product only
  assign prod_lo   = key_r * hash_factor_r;
  assign home      = PB'(prod_r >> hash_shift_r) & mask_r;
  assign rd_addr   = cmd.issue ? AW'(home) : AW'(pos_r);
  assign pos_nxt   = PB'((cmd.issue ? home : pos_r) + 1'b1) & mask_r;

  assign is_empty = (rdata_r == EMPTY_KEY);
  assign is_match = (rdata_r == key_r);
  assign vis_inc  = visited_r + 1'b1;
  assign hit_lap  = (vis_inc == active_r);

  always_ff @(posedge clk) begin
    if (cmd.load_probe) begin
      key_r <= in_key;
    end
    if (cmd.hash) begin
      prod_r   <= prod_lo;
      mask_r   <= PB'(act_cnt - 1'b1);
      active_r <= act_cnt;
    end
    if (cmd.issue || cmd.walk) begin
      pos_r <= pos_nxt;
    end
    if (cmd.issue) begin
      visited_r <= '0;
      count_r   <= '0;
      lap_r     <= 1'b0;
    end else if (cmd.walk) begin
      if (!is_empty) begin
        visited_r <= vis_inc;
        if (is_match) count_r <= count_r + 1'b1;
      end
      lap_r <= !is_empty && hit_lap;
    end
  end

  // running total and result register
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             out_valid_r;

  assign total_nxt = total_r + TOT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        total_r <= total_nxt;
      end
      out_valid_r <= cmd.finish || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_match_count   <= CNT_W'(count_r);
      out_total_matches <= total_nxt;
      out_full_lap      <= lap_r;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.clear_last = (clr_r == AW'(SLOTS - 1));
  assign stat.walk_stop  = is_empty || (is_match && early_stop_r) || hit_lap;
  assign stat.out_free   = !out_valid_r || !out_stall;

endmodule

// ===== rtl/hash_join_linear_probe.sv =====
// ----------------------------------------------------------------------------
// hash_join_linear_probe
// Probe side of a linear-probing hash join over a table of 32-bit keys.
// ----------------------------------------------------------------------------
//  Channel | Direction | Ports                                    | Handshake
//  --------+-----------+------------------------------------------+-------------
//  in      | input     | in_opcode, in_slot_index, in_key         | valid/stall
//  out     | output    | out_match_count, out_total_matches,      | valid/stall
//          |           | out_full_lap                             |
//  cfg     | input     | cfg_index, cfg_wdata                     | cfg_we only
//
//  A write item is written to the table at its accepting edge. A probe item
//  holds the input through the hash, issue, walk and finish states; its result
//  is registered as the controller returns to idle, where the next item can be
//  taken. The walk makes one table read per cycle through the single registered
//  read port of the table. After reset the table is swept to empty, one slot a
//  cycle, with in_stall high; config writes are taken during the sweep.
//  A waiting result sits in the output register; the next item is accepted
//  meanwhile, and a probe only holds at its last step if that register is
//  still occupied.
// ----------------------------------------------------------------------------
module hash_join_linear_probe
  import hjlp_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [IDX_W-1:0]      in_slot_index,
  input  logic [KEY_W-1:0]      in_key,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      out_match_count,
  output logic [TOT_W-1:0]      out_total_matches,
  output logic                  out_full_lap
);

  cmd_t  cmd;
  stat_t stat;

  // controller: clear sweep, item accept, hash, walk, result handoff
  hjlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: key table, hash multiplier, walk counters, totals
  hjlp_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_slot_index     (in_slot_index),
    .in_key            (in_key),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_match_count   (out_match_count),
    .out_total_matches (out_total_matches),
    .out_full_lap      (out_full_lap)
  );

endmodule

// ===== rtl/hjlp_checker.sv =====
// ----------------------------------------------------------------------------
// hjlp_checker
// Port-level checks for the hash join probe block, bound to the top level.
// ----------------------------------------------------------------------------
`include "hash_join_linear_probe_macros.svh"

module hjlp_checker
  import hjlp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CNT_W-1:0]      out_match_count,
  input logic [TOT_W-1:0]      out_total_matches,
  input logic                  out_full_lap
);

  logic                 out_held;
  logic [CNT_W+TOT_W:0] out_item;

  assign out_held = out_valid && out_stall;
  assign out_item = {out_match_count, out_total_matches, out_full_lap};

  // reset starts the clear sweep: no item taken, no result shown
  `HJLP_ASSERT_NEXT(a_reset_sweep, clk, !rst_n, in_stall && !out_valid)

  // a walk never counts more than the largest table
  `HJLP_ASSERT_NOW(a_count_range, clk, rst_n && out_valid, out_match_count <= 11'd1024)

  // a stalled result holds
  `HJLP_ASSERT_NEXT(a_out_hold, clk, rst_n && out_held, !rst_n || (out_valid && $stable(out_item)))

endmodule

bind hash_join_linear_probe hjlp_checker u_hjlp_checker (.*);
